>>> rtl/prac_pkg.sv
// shared types and constants for the point rotation block
package prac_pkg;

    localparam int COORD_W     = 32;
    localparam int TRIG_W      = 18;
    localparam int TRIG_FRAC   = 16;
    localparam int D_W         = COORD_W + 1;
    localparam int SH_W        = $clog2(COORD_W);
    localparam int NORM_TOP    = COORD_W - 2;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int ROOT_W      = COORD_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DVD_W       = COORD_W + TRIG_FRAC;
    localparam int Q_W         = TRIG_FRAC + 1;
    localparam int DIV_STAGES  = Q_W;
    localparam int U_W         = TRIG_FRAC + 2;
    localparam int K_W         = TRIG_W + 1;
    localparam int UU_W        = 2 * U_W;
    localparam int UUK_W       = UU_W + K_W;
    localparam int S_W         = TRIG_W + 3;
    localparam int MAT_W       = TRIG_W + 3;
    localparam int PRD_W       = D_W + MAT_W;
    localparam int ACC_W       = PRD_W + 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic signed [TRIG_W-1:0] COS_RESET = TRIG_W'(1 << TRIG_FRAC);
    localparam logic signed [U_W-1:0]    U_ONE     = U_W'(1 << TRIG_FRAC);

    typedef enum logic [1:0] {
        OP_ROT_X    = 2'd0,
        OP_ROT_Y    = 2'd1,
        OP_ROT_Z    = 2'd2,
        OP_ROT_AXIS = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_ANGLE = 2'd0,
        CFG_SIN_ANGLE = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        op_t                       op;
        logic                      inv;
        logic [2:0]                cneg;
        logic [2:0][D_W-1:0]       d;
        logic [2:0][COORD_W-1:0]   c;
    } side_t;

    typedef struct packed {
        logic [COORD_W-1:0] rotated_x;
        logic [COORD_W-1:0] rotated_y;
        logic [COORD_W-1:0] rotated_z;
        logic               axis_invalid;
    } res_t;

endpackage

>>> rtl/prac_if.sv
// point and result channel interfaces
interface prac_point_if;
    logic                                  valid;
    logic                                  ready;
    prac_pkg::op_t                         opcode;
    logic signed [prac_pkg::COORD_W-1:0]   point_x;
    logic signed [prac_pkg::COORD_W-1:0]   point_y;
    logic signed [prac_pkg::COORD_W-1:0]   point_z;
    logic signed [prac_pkg::COORD_W-1:0]   center_x;
    logic signed [prac_pkg::COORD_W-1:0]   center_y;
    logic signed [prac_pkg::COORD_W-1:0]   center_z;

    modport source (
        output valid, opcode, point_x, point_y, point_z, center_x, center_y, center_z,
        input  ready
    );
    modport sink (
        input  valid, opcode, point_x, point_y, point_z, center_x, center_y, center_z,
        output ready
    );
endinterface

interface prac_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [prac_pkg::COORD_W-1:0]   rotated_x;
    logic signed [prac_pkg::COORD_W-1:0]   rotated_y;
    logic signed [prac_pkg::COORD_W-1:0]   rotated_z;
    logic                                  axis_invalid;

    modport source (
        output valid, rotated_x, rotated_y, rotated_z, axis_invalid,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y, rotated_z, axis_invalid,
        output ready
    );
endinterface

>>> rtl/prac_isqrt.sv
// pipelined integer square root, one root bit per stage
module prac_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [prac_pkg::SQ_W-1:0]     rad,
    output logic [prac_pkg::ROOT_W-1:0]   root
);

    localparam int N     = prac_pkg::SQRT_STAGES;
    localparam int SQ_W  = prac_pkg::SQ_W;
    localparam int RT_W  = prac_pkg::ROOT_W;
    localparam int REM_W = RT_W + 2;

    logic [REM_W-1:0] rem_reg   [N-1];
    logic [SQ_W-1:0]  rad_reg   [N-1];
    logic [RT_W-1:0]  root_reg  [N];

    logic [REM_W-1:0] rem_prev  [N];
    logic [SQ_W-1:0]  rad_prev  [N];
    logic [RT_W-1:0]  root_prev [N];
    logic [REM_W+1:0] acc       [N];
    logic [REM_W+1:0] trial     [N];
    logic [REM_W-1:0] rem_next  [N];
    logic [SQ_W-1:0]  rad_next  [N];
    logic [RT_W-1:0]  root_next [N];

    always_comb
    begin
        rem_prev[0]  = '0;
        root_prev[0] = '0;
        rad_prev[0]  = rad;
        for (int k = 1; k < N; k++)
        begin
            rem_prev[k]  = rem_reg[k-1];
            root_prev[k] = root_reg[k-1];
            rad_prev[k]  = rad_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            acc[k]   = {rem_prev[k], rad_prev[k][SQ_W-1 -: 2]};
            trial[k] = {2'b00, root_prev[k], 2'b01};
            if (acc[k] >= trial[k])
            begin
                rem_next[k]  = REM_W'(acc[k] - trial[k]);
                root_next[k] = {root_prev[k][RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = acc[k][REM_W-1:0];
                root_next[k] = {root_prev[k][RT_W-2:0], 1'b0};
            end
            rad_next[k] = {rad_prev[k][SQ_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                root_reg[k] <= root_next[k];
            end
            for (int k = 0; k < N - 1; k++)
            begin
                rem_reg[k] <= rem_next[k];
                rad_reg[k] <= rad_next[k];
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

>>> rtl/prac_div.sv
// pipelined restoring divider, one quotient bit per stage
module prac_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [prac_pkg::DVD_W-1:0]    dvd,
    input  logic [prac_pkg::ROOT_W-1:0]   dvs,
    output logic [prac_pkg::Q_W-1:0]      quo
);

    localparam int N     = prac_pkg::DIV_STAGES;
    localparam int Q_W   = prac_pkg::Q_W;
    localparam int R_W   = prac_pkg::ROOT_W;
    localparam int DVD_W = prac_pkg::DVD_W;

    logic [R_W-1:0] rem_reg  [N-1];
    logic [Q_W-1:0] lo_reg   [N-1];
    logic [R_W-1:0] dvs_reg  [N-1];
    logic [Q_W-1:0] q_reg    [N];

    logic [R_W-1:0] rem_prev [N];
    logic [Q_W-1:0] lo_prev  [N];
    logic [R_W-1:0] dvs_prev [N];
    logic [Q_W-1:0] q_prev   [N];
    logic [R_W:0]   acc      [N];
    logic [R_W-1:0] rem_next [N];
    logic [Q_W-1:0] lo_next  [N];
    logic [Q_W-1:0] q_next   [N];

    always_comb
    begin
        rem_prev[0] = R_W'(dvd[DVD_W-1:Q_W]);
        lo_prev[0]  = dvd[Q_W-1:0];
        dvs_prev[0] = dvs;
        q_prev[0]   = '0;
        for (int k = 1; k < N; k++)
        begin
            rem_prev[k] = rem_reg[k-1];
            lo_prev[k]  = lo_reg[k-1];
            dvs_prev[k] = dvs_reg[k-1];
            q_prev[k]   = q_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            acc[k] = {rem_prev[k], lo_prev[k][Q_W-1]};
            if (acc[k] >= {1'b0, dvs_prev[k]})
            begin
                rem_next[k] = R_W'(acc[k] - {1'b0, dvs_prev[k]});
                q_next[k]   = {q_prev[k][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = acc[k][R_W-1:0];
                q_next[k]   = {q_prev[k][Q_W-2:0], 1'b0};
            end
            lo_next[k] = {lo_prev[k][Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                q_reg[k] <= q_next[k];
            end
            for (int k = 0; k < N - 1; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                dvs_reg[k] <= dvs_prev[k];
            end
        end
    end

    assign quo = q_reg[N-1];

endmodule

>>> rtl/point_rotation_about_center.sv
// top level: rotation of a point about a center by a programmed step angle
// Rotates one Q16.16 point per word about an axis through the center, using the cos_angle and
// sin_angle registers (Q1.16). Opcodes 0 to 2 use the X, Y or Z axis; opcode 3 uses the
// normalized center vector, and a zero center there returns the point unchanged with
// axis_invalid set. A new word is taken every cycle while the skid stage is empty. The pipe
// holds the 32-stage square root (one root bit per stage) and the 17-stage divider (one
// quotient bit per stage) that build the unit axis, plus 13 arithmetic and output stages.
// An output register with a skid stage keeps the input open while one result waits.
// Write the angle registers only while no word is in flight. No clearing pass after reset.
module point_rotation_about_center (
    input  logic                                clk,
    input  logic                                rst_n,
    prac_point_if.sink                          point,
    prac_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [prac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prac_pkg::TRIG_W-1:0]         cfg_data
);

    localparam int COORD_W = prac_pkg::COORD_W;
    localparam int TRIG_W  = prac_pkg::TRIG_W;
    localparam int FRAC    = prac_pkg::TRIG_FRAC;
    localparam int D_W     = prac_pkg::D_W;
    localparam int SH_W    = prac_pkg::SH_W;
    localparam int SQ_W    = prac_pkg::SQ_W;
    localparam int ROOT_W  = prac_pkg::ROOT_W;
    localparam int NSQ     = prac_pkg::SQRT_STAGES;
    localparam int NDV     = prac_pkg::DIV_STAGES;
    localparam int DVD_W   = prac_pkg::DVD_W;
    localparam int Q_W     = prac_pkg::Q_W;
    localparam int U_W     = prac_pkg::U_W;
    localparam int K_W     = prac_pkg::K_W;
    localparam int UU_W    = prac_pkg::UU_W;
    localparam int UUK_W   = prac_pkg::UUK_W;
    localparam int S_W     = prac_pkg::S_W;
    localparam int MAT_W   = prac_pkg::MAT_W;
    localparam int PRD_W   = prac_pkg::PRD_W;
    localparam int ACC_W   = prac_pkg::ACC_W;

    localparam int UU_XX = 0;
    localparam int UU_YY = 1;
    localparam int UU_ZZ = 2;
    localparam int UU_XY = 3;
    localparam int UU_XZ = 4;
    localparam int UU_YZ = 5;

    localparam logic signed [UU_W-1:0]  SPROD_HALF = UU_W'(64'd1 << (FRAC - 1));
    localparam logic signed [UUK_W-1:0] UUK_HALF   = UUK_W'(64'd1 << (2 * FRAC - 1));
    localparam logic signed [ACC_W-1:0] ACC_HALF   = ACC_W'(64'd1 << (FRAC - 1));
    localparam logic signed [K_W-1:0]   K_ONE      = K_W'(1 << FRAC);

    // configuration
    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= prac_pkg::COS_RESET;
            sin_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                prac_pkg::CFG_COS_ANGLE: cos_reg <= cfg_data;
                prac_pkg::CFG_SIN_ANGLE: sin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_vld_reg;
    logic out_vld_reg;
    prac_pkg::res_t skid_reg;
    prac_pkg::res_t out_reg;

    assign en          = !skid_vld_reg;
    assign point.ready = en;

    // stage registers
    logic                        st1_vld_reg;
    prac_pkg::op_t               st1_op_reg;
    logic signed [COORD_W-1:0]   st1_p_reg [3];
    logic signed [COORD_W-1:0]   st1_c_reg [3];

    logic                        st2_vld_reg;
    prac_pkg::side_t             st2_side_reg;
    logic [COORD_W-1:0]          st2_m_reg [3];
    logic [SH_W-1:0]             st2_sh_reg;

    logic                        st3_vld_reg;
    prac_pkg::side_t             st3_side_reg;
    logic [2:0][COORD_W-1:0]     st3_ms_reg;

    logic                        st4_vld_reg;
    prac_pkg::side_t             st4_side_reg;
    logic [2:0][COORD_W-1:0]     st4_ms_reg;
    logic [SQ_W-1:0]             st4_sq_reg [3];

    logic                        st5_vld_reg;
    prac_pkg::side_t             st5_side_reg;
    logic [2:0][COORD_W-1:0]     st5_ms_reg;
    logic [SQ_W-1:0]             st5_sum_reg;

    logic [NSQ-1:0]              sq_vld_reg;
    prac_pkg::side_t             sq_side_reg [NSQ];
    logic [2:0][COORD_W-1:0]     sq_ms_reg [NSQ];

    logic                        st6_vld_reg;
    prac_pkg::side_t             st6_side_reg;
    logic [DVD_W-1:0]            st6_dvd_reg [3];
    logic [ROOT_W-1:0]           st6_root_reg;

    logic [NDV-1:0]              dv_vld_reg;
    prac_pkg::side_t             dv_side_reg [NDV];

    logic                        st7_vld_reg;
    prac_pkg::side_t             st7_side_reg;
    logic signed [U_W-1:0]       st7_u_reg [3];

    logic                        st8_vld_reg;
    prac_pkg::side_t             st8_side_reg;
    logic signed [UU_W-1:0]      st8_sprod_reg [3];
    logic signed [UU_W-1:0]      st8_uu_reg [6];

    logic                        st9_vld_reg;
    prac_pkg::side_t             st9_side_reg;
    logic signed [S_W-1:0]       st9_s_reg [3];
    logic signed [UUK_W-1:0]     st9_uuk_reg [6];

    logic                        st10_vld_reg;
    prac_pkg::side_t             st10_side_reg;
    logic signed [MAT_W-1:0]     st10_mat_reg [3][3];

    logic                        st11_vld_reg;
    prac_pkg::side_t             st11_side_reg;
    logic signed [PRD_W-1:0]     st11_prod_reg [3][3];

    logic                        st12_vld_reg;
    prac_pkg::side_t             st12_side_reg;
    logic signed [ACC_W-1:0]     st12_acc_reg [3];

    // combinational stage logic
    logic signed [D_W-1:0]       d1 [3];
    logic [COORD_W-1:0]          m1 [3];
    logic [COORD_W-1:0]          mx1;
    logic [SH_W-1:0]             msb1;
    logic [SH_W-1:0]             sh1;
    prac_pkg::side_t             side1;
    logic [COORD_W-1:0]          ms2 [3];
    logic [SQ_W-1:0]             sq3 [3];
    logic [SQ_W-1:0]             sum4;
    logic [ROOT_W-1:0]           root;
    logic [DVD_W-1:0]            dvd5 [3];
    logic [Q_W-1:0]              quo [3];
    logic signed [U_W-1:0]       u6 [3];
    logic signed [UU_W-1:0]      sprod7 [3];
    logic signed [UU_W-1:0]      uu7 [6];
    logic signed [K_W-1:0]       k8;
    logic signed [S_W-1:0]       s8 [3];
    logic signed [UUK_W-1:0]     uuk8 [6];
    logic signed [MAT_W-1:0]     r9 [6];
    logic signed [MAT_W-1:0]     mat9 [3][3];
    logic signed [PRD_W-1:0]     prod10 [3][3];
    logic signed [ACC_W-1:0]     acc11 [3];
    logic [COORD_W-1:0]          rot12 [3];
    logic [COORD_W-1:0]          pass12 [3];
    prac_pkg::res_t              res12;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1[i] = D_W'(st1_p_reg[i]) - D_W'(st1_c_reg[i]);
            m1[i] = st1_c_reg[i][COORD_W-1] ? COORD_W'(-st1_c_reg[i]) : COORD_W'(st1_c_reg[i]);
        end
        mx1 = m1[0];
        if (m1[1] > mx1)
        begin
            mx1 = m1[1];
        end
        if (m1[2] > mx1)
        begin
            mx1 = m1[2];
        end
        msb1 = '0;
        for (int b = 0; b < COORD_W; b++)
        begin
            if (mx1[b])
            begin
                msb1 = SH_W'(b);
            end
        end
        sh1 = mx1[COORD_W-1] ? '0 : SH_W'(prac_pkg::NORM_TOP - int'(msb1));
        side1.op  = st1_op_reg;
        side1.inv = (st1_op_reg == prac_pkg::OP_ROT_AXIS) && (mx1 == '0);
        for (int i = 0; i < 3; i++)
        begin
            side1.cneg[i] = st1_c_reg[i][COORD_W-1];
            side1.d[i]    = d1[i];
            side1.c[i]    = st1_c_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ms2[i]  = st2_m_reg[i] << st2_sh_reg;
            sq3[i]  = SQ_W'(st3_ms_reg[i]) * SQ_W'(st3_ms_reg[i]);
            dvd5[i] = {sq_ms_reg[NSQ-1][i], {FRAC{1'b0}}} + DVD_W'(root >> 1);
        end
        sum4 = st4_sq_reg[0] + st4_sq_reg[1] + st4_sq_reg[2];
    end

    prac_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (st5_sum_reg),
        .root (root)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        prac_div u_div (
            .clk (clk),
            .en  (en),
            .dvd (st6_dvd_reg[i]),
            .dvs (st6_root_reg),
            .quo (quo[i])
        );
    end

    // unit axis, matrix, rotation products and result select
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (dv_side_reg[NDV-1].op)
                prac_pkg::OP_ROT_AXIS:
                begin
                    u6[i] = dv_side_reg[NDV-1].cneg[i] ? -$signed({1'b0, quo[i]})
                                                       : $signed({1'b0, quo[i]});
                end
                default:
                begin
                    u6[i] = (int'(dv_side_reg[NDV-1].op) == i) ? prac_pkg::U_ONE : '0;
                end
            endcase
            sprod7[i] = UU_W'(st7_u_reg[i]) * UU_W'(sin_reg);
        end
        uu7[UU_XX] = UU_W'(st7_u_reg[0]) * UU_W'(st7_u_reg[0]);
        uu7[UU_YY] = UU_W'(st7_u_reg[1]) * UU_W'(st7_u_reg[1]);
        uu7[UU_ZZ] = UU_W'(st7_u_reg[2]) * UU_W'(st7_u_reg[2]);
        uu7[UU_XY] = UU_W'(st7_u_reg[0]) * UU_W'(st7_u_reg[1]);
        uu7[UU_XZ] = UU_W'(st7_u_reg[0]) * UU_W'(st7_u_reg[2]);
        uu7[UU_YZ] = UU_W'(st7_u_reg[1]) * UU_W'(st7_u_reg[2]);

        k8 = K_ONE - K_W'(cos_reg);
        for (int i = 0; i < 3; i++)
        begin
            s8[i] = S_W'((st8_sprod_reg[i] + SPROD_HALF) >>> FRAC);
        end
        for (int n = 0; n < 6; n++)
        begin
            uuk8[n] = UUK_W'(st8_uu_reg[n]) * UUK_W'(k8);
            r9[n]   = MAT_W'((st9_uuk_reg[n] + UUK_HALF) >>> (2 * FRAC));
        end

        mat9[0][0] = MAT_W'(cos_reg) + r9[UU_XX];
        mat9[1][1] = MAT_W'(cos_reg) + r9[UU_YY];
        mat9[2][2] = MAT_W'(cos_reg) + r9[UU_ZZ];
        mat9[0][1] = r9[UU_XY] - st9_s_reg[2];
        mat9[0][2] = r9[UU_XZ] + st9_s_reg[1];
        mat9[1][0] = r9[UU_XY] + st9_s_reg[2];
        mat9[1][2] = r9[UU_YZ] - st9_s_reg[0];
        mat9[2][0] = r9[UU_XZ] - st9_s_reg[1];
        mat9[2][1] = r9[UU_YZ] + st9_s_reg[0];

        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod10[i][j] = PRD_W'($signed(st10_side_reg.d[j])) * PRD_W'(st10_mat_reg[i][j]);
            end
            acc11[i] = ACC_W'(st11_prod_reg[i][0]) + ACC_W'(st11_prod_reg[i][1])
                       + ACC_W'(st11_prod_reg[i][2]);
            rot12[i] = COORD_W'((st12_acc_reg[i] + ACC_HALF) >>> FRAC) + st12_side_reg.c[i];
            pass12[i] = st12_side_reg.d[i][COORD_W-1:0] + st12_side_reg.c[i];
        end
        res12.rotated_x    = st12_side_reg.inv ? pass12[0] : rot12[0];
        res12.rotated_y    = st12_side_reg.inv ? pass12[1] : rot12[1];
        res12.rotated_z    = st12_side_reg.inv ? pass12[2] : rot12[2];
        res12.axis_invalid = st12_side_reg.inv;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_vld_reg  <= 1'b0;
            st2_vld_reg  <= 1'b0;
            st3_vld_reg  <= 1'b0;
            st4_vld_reg  <= 1'b0;
            st5_vld_reg  <= 1'b0;
            sq_vld_reg   <= '0;
            st6_vld_reg  <= 1'b0;
            dv_vld_reg   <= '0;
            st7_vld_reg  <= 1'b0;
            st8_vld_reg  <= 1'b0;
            st9_vld_reg  <= 1'b0;
            st10_vld_reg <= 1'b0;
            st11_vld_reg <= 1'b0;
            st12_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            st1_vld_reg  <= point.valid;
            st2_vld_reg  <= st1_vld_reg;
            st3_vld_reg  <= st2_vld_reg;
            st4_vld_reg  <= st3_vld_reg;
            st5_vld_reg  <= st4_vld_reg;
            sq_vld_reg   <= {sq_vld_reg[NSQ-2:0], st5_vld_reg};
            st6_vld_reg  <= sq_vld_reg[NSQ-1];
            dv_vld_reg   <= {dv_vld_reg[NDV-2:0], st6_vld_reg};
            st7_vld_reg  <= dv_vld_reg[NDV-1];
            st8_vld_reg  <= st7_vld_reg;
            st9_vld_reg  <= st8_vld_reg;
            st10_vld_reg <= st9_vld_reg;
            st11_vld_reg <= st10_vld_reg;
            st12_vld_reg <= st11_vld_reg;
        end
    end

    // pipeline data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_op_reg   <= point.opcode;
            st1_p_reg[0] <= point.point_x;
            st1_p_reg[1] <= point.point_y;
            st1_p_reg[2] <= point.point_z;
            st1_c_reg[0] <= point.center_x;
            st1_c_reg[1] <= point.center_y;
            st1_c_reg[2] <= point.center_z;

            st2_side_reg <= side1;
            st2_sh_reg   <= sh1;
            st3_side_reg <= st2_side_reg;
            st4_side_reg <= st3_side_reg;
            st4_ms_reg   <= st3_ms_reg;
            st5_side_reg <= st4_side_reg;
            st5_ms_reg   <= st4_ms_reg;
            st5_sum_reg  <= sum4;
            for (int i = 0; i < 3; i++)
            begin
                st2_m_reg[i]  <= m1[i];
                st3_ms_reg[i] <= ms2[i];
                st4_sq_reg[i] <= sq3[i];
            end

            sq_side_reg[0] <= st5_side_reg;
            sq_ms_reg[0]   <= st5_ms_reg;
            for (int k = 1; k < NSQ; k++)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
                sq_ms_reg[k]   <= sq_ms_reg[k-1];
            end

            st6_side_reg <= sq_side_reg[NSQ-1];
            st6_root_reg <= root;
            for (int i = 0; i < 3; i++)
            begin
                st6_dvd_reg[i] <= dvd5[i];
            end

            dv_side_reg[0] <= st6_side_reg;
            for (int k = 1; k < NDV; k++)
            begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end

            st7_side_reg  <= dv_side_reg[NDV-1];
            st8_side_reg  <= st7_side_reg;
            st9_side_reg  <= st8_side_reg;
            st10_side_reg <= st9_side_reg;
            st11_side_reg <= st10_side_reg;
            st12_side_reg <= st11_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                st7_u_reg[i]     <= u6[i];
                st8_sprod_reg[i] <= sprod7[i];
                st9_s_reg[i]     <= s8[i];
                st12_acc_reg[i]  <= acc11[i];
                for (int j = 0; j < 3; j++)
                begin
                    st10_mat_reg[i][j]  <= mat9[i][j];
                    st11_prod_reg[i][j] <= prod10[i][j];
                end
            end
            for (int n = 0; n < 6; n++)
            begin
                st8_uu_reg[n]  <= uu7[n];
                st9_uuk_reg[n] <= uuk8[n];
            end
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (out_vld_reg && !result.ready)
            begin
                skid_vld_reg <= st12_vld_reg;
            end
            else
            begin
                out_vld_reg <= st12_vld_reg;
            end
        end
        else if (result.ready)
        begin
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (out_vld_reg && !result.ready)
            begin
                skid_reg <= res12;
            end
            else
            begin
                out_reg <= res12;
            end
        end
        else if (result.ready)
        begin
            out_reg <= skid_reg;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.rotated_x    = out_reg.rotated_x;
    assign result.rotated_y    = out_reg.rotated_y;
    assign result.rotated_z    = out_reg.rotated_z;
    assign result.axis_invalid = out_reg.axis_invalid;

endmodule

>>> rtl/prac_checker.sv
// port checker for the point rotation block and its bind
module prac_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           point_ready,
    input logic                           result_valid,
    input logic                           result_ready,
    input logic [prac_pkg::COORD_W-1:0]   rotated_x,
    input logic [prac_pkg::COORD_W-1:0]   rotated_y,
    input logic [prac_pkg::COORD_W-1:0]   rotated_z,
    input logic                           axis_invalid
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(rotated_x) && $stable(rotated_y)
                                          && $stable(rotated_z) && $stable(axis_invalid))
        else $error("result word changed while stalled");

    // input closes only behind a waiting result
    a_busy_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> result_valid)
        else $error("input closed with no result waiting");

    a_busy_stays: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && !point_ready |=> !point_ready)
        else $error("input reopened while output stalled and skid full");

endmodule

bind point_rotation_about_center prac_checker u_prac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_ready  (point.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .rotated_x    (result.rotated_x),
    .rotated_y    (result.rotated_y),
    .rotated_z    (result.rotated_z),
    .axis_invalid (result.axis_invalid)
);
